// ===== sv/cfd_pkg.sv =====
// Shared types, constants and helper functions for the CRC frame byte decoder.
package cfd_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 256;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Reset values of the configuration registers.
  localparam logic [7:0]  START_BYTE_RST  = 8'h7E;
  localparam logic [7:0]  VERSION_RST     = 8'h01;
  localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd256;
  localparam logic [15:0] CRC_SEED_RST    = 16'hFFFF;
  localparam logic [47:0] KNOWN_TYPES_RST = 48'h0605_0403_0201;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BYTE  = 3'd0,
    CFG_VERSION     = 3'd1,
    CFG_MAX_PAYLOAD = 3'd2,
    CFG_CRC_SEED    = 3'd3,
    CFG_KNOWN_TYPES = 3'd4
  } cfg_reg_e;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_OK   = 3'd1,
    EV_CRC  = 3'd2,
    EV_TYPE = 3'd3,
    EV_LEN  = 3'd4,
    EV_READ = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_VER  = 3'd1,
    PH_HDR  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRC  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  version_byte;
    logic [8:0]  max_payload;
    logic [15:0] crc_seed;
    logic [47:0] known_type_codes;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  frame_type;
    logic [7:0]  sequence_res;
    logic [15:0] frame_length;
    logic [7:0]  read_data;
    logic [31:0] crc_error_count;
    logic [31:0] unknown_type_count;
    logic [31:0] length_error_count;
  } res_t;

  // One byte through CRC-16 with polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // True when the type byte matches any of the six packed codes.
  function automatic logic type_known(logic [47:0] codes, logic [7:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (codes[8*i +: 8] == t) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== sv/cfd_stream_if.sv =====
// Valid/ready stream interface that carries one word of a given payload type.
interface cfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/cfd_deframer.sv =====
// Deframer state machine, payload buffer and registered result stage.
module cfd_deframer #(
  parameter int unsigned PayloadDepth = cfd_pkg::PAYLOAD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfd_pkg::in_t  item_i,
  input  cfd_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output cfd_pkg::res_t res_o
);

  localparam int unsigned AW = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;
  localparam int unsigned PW = $clog2(PayloadDepth + 1);
  localparam int unsigned IW = (AW > 8) ? AW : 8;

  cfd_pkg::phase_e phase_q, phase_d;
  logic [1:0]    hdr_pos_q, hdr_pos_d;
  logic [7:0]    held_type_q, held_type_d;
  logic [7:0]    held_seq_q, held_seq_d;
  logic [15:0]   held_len_q, held_len_d;
  logic [PW-1:0] pay_pos_q, pay_pos_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   rcv_crc_q, rcv_crc_d;
  logic [1:0]    crc_pos_q, crc_pos_d;
  logic [31:0]   crc_err_q, crc_err_d;
  logic [31:0]   type_err_q, type_err_d;
  logic [31:0]   len_err_q, len_err_d;

  cfd_pkg::event_e ev;
  logic       frame_open;
  logic       mem_we;
  logic [7:0] b;

  logic [7:0]    mem [PayloadDepth];
  logic [7:0]    mem_rd_q;
  logic [IW-1:0] rd_idx_ext;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;

  logic          s1_valid_q;
  cfd_pkg::res_t s1_q;
  logic          s1_rd_ok_q;

  assign b          = item_i.rx_byte;
  assign rd_idx_ext = IW'(item_i.read_index);
  assign rd_addr    = rd_idx_ext[AW-1:0];
  assign rd_ok      = 32'(item_i.read_index) < 32'(PayloadDepth);

  always_comb begin
    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    held_type_d = held_type_q;
    held_seq_d  = held_seq_q;
    held_len_d  = held_len_q;
    pay_pos_d   = pay_pos_q;
    crc_d       = crc_q;
    rcv_crc_d   = rcv_crc_q;
    crc_pos_d   = crc_pos_q;
    crc_err_d   = crc_err_q;
    type_err_d  = type_err_q;
    len_err_d   = len_err_q;
    ev          = cfd_pkg::EV_NONE;
    frame_open  = 1'b0;
    mem_we      = 1'b0;

    if (push_i) begin
      if (item_i.operation == cfd_pkg::OP_READ) begin
        ev = cfd_pkg::EV_READ;
      end else begin
        case (phase_q)
          cfd_pkg::PH_HUNT: begin
            if (b == cfg_i.start_byte) frame_open = 1'b1;
          end
          cfd_pkg::PH_VER: begin
            if (b == cfg_i.version_byte) begin
              crc_d   = cfd_pkg::crc16_byte(crc_q, b);
              phase_d = cfd_pkg::PH_HDR;
            end else if (b == cfg_i.start_byte) begin
              // A second start byte re-anchors the frame here.
              frame_open = 1'b1;
            end else begin
              phase_d = cfd_pkg::PH_HUNT;
            end
          end
          cfd_pkg::PH_HDR: begin
            crc_d = cfd_pkg::crc16_byte(crc_q, b);
            case (hdr_pos_q)
              2'd0:    held_type_d = b;
              2'd1:    held_seq_d  = b;
              2'd2:    held_len_d  = {b, 8'h00};
              default: held_len_d  = held_len_q | {8'h00, b};
            endcase
            if (hdr_pos_q == 2'd3) begin
              hdr_pos_d = 2'd0;
              if ((held_len_d > {7'd0, cfg_i.max_payload}) ||
                  (32'(held_len_d) > 32'(PayloadDepth))) begin
                len_err_d = len_err_q + 32'd1;
                ev        = cfd_pkg::EV_LEN;
                phase_d   = cfd_pkg::PH_HUNT;
              end else if (held_len_d == 16'd0) begin
                phase_d = cfd_pkg::PH_CRC;
              end else begin
                pay_pos_d = '0;
                phase_d   = cfd_pkg::PH_PAY;
              end
            end else begin
              hdr_pos_d = hdr_pos_q + 2'd1;
            end
          end
          cfd_pkg::PH_PAY: begin
            crc_d     = cfd_pkg::crc16_byte(crc_q, b);
            mem_we    = 1'b1;
            pay_pos_d = pay_pos_q + PW'(1);
            if (16'(pay_pos_d) >= held_len_q) phase_d = cfd_pkg::PH_CRC;
          end
          cfd_pkg::PH_CRC: begin
            rcv_crc_d = {rcv_crc_q[7:0], b};
            crc_pos_d = crc_pos_q + 2'd1;
            if (crc_pos_d >= 2'd2) begin
              if (rcv_crc_d != crc_q) begin
                crc_err_d = crc_err_q + 32'd1;
                ev        = cfd_pkg::EV_CRC;
              end else if (!cfd_pkg::type_known(cfg_i.known_type_codes, held_type_q)) begin
                type_err_d = type_err_q + 32'd1;
                ev         = cfd_pkg::EV_TYPE;
              end else begin
                ev = cfd_pkg::EV_OK;
              end
              phase_d = cfd_pkg::PH_HUNT;
            end
          end
          default: phase_d = cfd_pkg::PH_HUNT;
        endcase
      end
    end

    if (frame_open) begin
      crc_d      = cfg_i.crc_seed;
      hdr_pos_d  = 2'd0;
      pay_pos_d  = '0;
      crc_pos_d  = 2'd0;
      rcv_crc_d  = 16'd0;
      held_len_d = 16'd0;
      phase_d    = cfd_pkg::PH_VER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfd_pkg::PH_HUNT;
      hdr_pos_q   <= 2'd0;
      held_type_q <= 8'd0;
      held_seq_q  <= 8'd0;
      held_len_q  <= 16'd0;
      pay_pos_q   <= '0;
      crc_q       <= 16'd0;
      rcv_crc_q   <= 16'd0;
      crc_pos_q   <= 2'd0;
      crc_err_q   <= 32'd0;
      type_err_q  <= 32'd0;
      len_err_q   <= 32'd0;
      s1_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_pos_q   <= hdr_pos_d;
      held_type_q <= held_type_d;
      held_seq_q  <= held_seq_d;
      held_len_q  <= held_len_d;
      pay_pos_q   <= pay_pos_d;
      crc_q       <= crc_d;
      rcv_crc_q   <= rcv_crc_d;
      crc_pos_q   <= crc_pos_d;
      crc_err_q   <= crc_err_d;
      type_err_q  <= type_err_d;
      len_err_q   <= len_err_d;
      s1_valid_q  <= push_i;
    end
  end

  // Result stage; read data comes from the buffer's read register, loaded at the same edge.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      s1_q.event_res          <= ev;
      s1_q.frame_type         <= held_type_d;
      s1_q.sequence_res       <= held_seq_d;
      s1_q.frame_length       <= held_len_d;
      s1_q.read_data          <= 8'd0;
      s1_q.crc_error_count    <= crc_err_d;
      s1_q.unknown_type_count <= type_err_d;
      s1_q.length_error_count <= len_err_d;
      s1_rd_ok_q              <= (item_i.operation == cfd_pkg::OP_READ) && rd_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pay_pos_q[AW-1:0]] <= b;
    if (push_i && (item_i.operation == cfd_pkg::OP_READ)) mem_rd_q <= mem[rd_addr];
  end

  always_comb begin
    res_o           = s1_q;
    res_o.read_data = s1_rd_ok_q ? mem_rd_q : 8'd0;
  end

  assign res_valid_o = s1_valid_q;

  a_pay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cfd_pkg::PH_PAY) |-> (held_len_q != 16'd0 && 16'(pay_pos_q) < held_len_q))
    else $error("payload position outside the announced length");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> res_valid_o)
    else $error("accepted word produced no result");

  a_len_err_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.event_res == cfd_pkg::EV_LEN) |-> (res_o.frame_length != 16'd0))
    else $error("length error reported for an empty payload");

endmodule

// ===== sv/crc_frame_byte_decoder_top.sv =====
// Top level of the CRC frame byte decoder: configuration, deframer and result queue.
// A word accepted on in_i passes through the deframer's result stage register into the result queue,
// which presents it on out_o. Throughput: one word per cycle while the result queue has room.
// A four-entry result queue keeps input accepted while results wait downstream.
// Reset (rst_ni low, asynchronous) restores the configuration defaults, the hunt state,
// zero header fields and counters, and empties the queue; the payload buffer is not cleared.
module crc_frame_byte_decoder_top #(
  parameter int unsigned PayloadDepth = cfd_pkg::PAYLOAD_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cfd_stream_if.sink                       in_i,
  cfd_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned Depth = cfd_pkg::RES_FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 2);

  // Configuration registers. Writes to indexes beyond the list are dropped.
  cfd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte       <= cfd_pkg::START_BYTE_RST;
      cfg_q.version_byte     <= cfd_pkg::VERSION_RST;
      cfg_q.max_payload      <= cfd_pkg::MAX_PAYLOAD_RST;
      cfg_q.crc_seed         <= cfd_pkg::CRC_SEED_RST;
      cfg_q.known_type_codes <= cfd_pkg::KNOWN_TYPES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfd_pkg::CFG_START_BYTE:  cfg_q.start_byte       <= cfg_data_i[7:0];
        cfd_pkg::CFG_VERSION:     cfg_q.version_byte     <= cfg_data_i[7:0];
        cfd_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload      <= cfg_data_i[8:0];
        cfd_pkg::CFG_CRC_SEED:    cfg_q.crc_seed         <= cfg_data_i[15:0];
        cfd_pkg::CFG_KNOWN_TYPES: cfg_q.known_type_codes <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // The deframer updates its state at the accepting edge and registers each
  // result in its own stage register.
  logic          accept;
  logic          s1_valid;
  cfd_pkg::res_t s1_res;

  assign accept = in_i.valid && in_i.ready;

  cfd_deframer #(
    .PayloadDepth (PayloadDepth)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .item_i      (in_i.data),
    .cfg_i       (cfg_q),
    .res_valid_o (s1_valid),
    .res_o       (s1_res)
  );

  // Result queue. The result stage cannot stall, so input is taken only while
  // the queue has room for the word in the stage plus the new one.
  cfd_pkg::res_t   fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] reserved;
  logic            pop;

  assign reserved   = count_q + CntW'(s1_valid);
  assign in_i.ready = reserved < CntW'(Depth);
  assign out_o.valid = count_q != '0;
  assign out_o.data  = fifo_q[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    count_d = count_q;
    if (s1_valid && !pop) count_d = count_q + CntW'(1);
    else if (!s1_valid && pop) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s1_valid) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)      rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid) fifo_q[wr_ptr_q] <= s1_res;
  end

  // The queue plus the word in the result stage never overruns the queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved <= CntW'(Depth))
    else $error("result queue overrun");

  // A full queue must hold off the input side.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(Depth)) |-> !in_i.ready)
    else $error("input accepted with a full result queue");

  // An accepted word lands in the queue after the deframer's result stage register.
  a_word_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 (count_q != '0))
    else $error("accepted word missing from the result queue");

endmodule
